// File: rtl/tql_pkg.sv
// ----------------------------------------------------------------------------
// tql_pkg
// Shared types and constants of the tabular Q-learning engine: item and
// result payloads, controller state, command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tql_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT_FACTOR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPLORATION_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXPLORATION_FLOOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXPLORATION_DECAY = 3'd4;

	// register reset values, unsigned Q0.16
	localparam logic [CFG_DATA_W-1:0] RST_LEARNING_RATE     = 16'd6554;
	localparam logic [CFG_DATA_W-1:0] RST_DISCOUNT_FACTOR   = 16'd58982;
	localparam logic [CFG_DATA_W-1:0] RST_EXPLORATION_START = 16'd6554;
	localparam logic [CFG_DATA_W-1:0] RST_EXPLORATION_FLOOR = 16'd655;
	localparam logic [CFG_DATA_W-1:0] RST_EXPLORATION_DECAY = 16'd65208;

	// round half up before dropping 16 fraction bits
	localparam int ROUND_BIAS = 32768;

	localparam logic [0:0] MODE_SELECT = 1'b0;
	localparam logic [0:0] MODE_UPDATE = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [14:0]       state_index;
		logic [2:0]        action_taken;
		logic signed [31:0] reward;
		logic [14:0]       next_state_index;
		logic [15:0]       explore_draw;
		logic [2:0]        explore_action;
	} item_t;

	typedef struct packed {
		logic [2:0]         chosen_action;
		logic               explored;
		logic signed [31:0] new_q_value;
		logic [15:0]        exploration_now;
		logic               index_error;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_SCAN_END,
		ST_Q_READ,
		ST_Q_WAIT,
		ST_MUL,
		ST_WRITE,
		ST_RESP
	} state_e;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic decide;
		logic scan_issue;
		logic q_read;
		logic q_capture;
		logic mul;
		logic write;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scan_last;
		logic err;
		logic explore;
		logic mode;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/tabular_q_learning_engine.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_engine
// Tabular Q-learning with epsilon-greedy action selection.
// ----------------------------------------------------------------------------
// Usage: drive item and raise start; the transaction is accepted at a rising
// edge with start high and busy low. Each transaction gives exactly one
// result, shown on result for one cycle while done is high; the receiver
// must take it then, it cannot stall the block.
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0..4
// selects learning rate, discount, exploration start (also loads the rate),
// exploration floor and decay. Other indexes are ignored.
// Sequence from accept to done:
//   select, exploring or index error: decision, then result
//   select, greedy: row scan (one table read per cycle over the row), result
//   update: row scan, entry read, multiplies, write, result
// A new transaction can already be accepted in the cycle before done, while
// the result is registered; the single table port keeps the rest serial.
// Reset: the value table is zeroed by a sweep over all STATE_COUNT * ACTION_COUNT
// entries, one entry per cycle, while busy stays high; configuration writes
// are taken during the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module tabular_q_learning_engine #(
	parameter int STATE_COUNT  = 32768,
	parameter int ACTION_COUNT = 5
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire tql_pkg::item_t                 item,
	output      logic                           busy,
	output      logic                           done,
	output      tql_pkg::result_t               result,
	input  wire logic                           cfg_valid,
	output      logic                           cfg_ready,
	input  wire logic [tql_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tql_pkg::CFG_DATA_W-1:0] cfg_data
);

	tql_pkg::cmd_t    cmd;
	tql_pkg::status_t status;
	logic             cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	tql_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.busy  (busy),
		.cmd   (cmd)
	);

	tql_dp #(
		.STATE_COUNT (STATE_COUNT),
		.ACTION_COUNT(ACTION_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

	a_done_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

// File: rtl/tql_ram.sv
// ----------------------------------------------------------------------------
// tql_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tql_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/tql_ctrl.sv
// ----------------------------------------------------------------------------
// tql_ctrl
// Sequencer of the Q-learning engine: table clear after reset, row scan,
// read-modify-write of one entry and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tql_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire tql_pkg::status_t status,
	output      logic             busy,
	output      tql_pkg::cmd_t    cmd
);

	tql_pkg::state_e state_q, state_d;
	logic            accept;

	// RESP only drives the result register, so a new transaction may enter there
	assign busy   = !(state_q == tql_pkg::ST_IDLE || state_q == tql_pkg::ST_RESP);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tql_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tql_pkg::ST_CLEAR: begin
				if (status.clear_last) state_d = tql_pkg::ST_IDLE;
			end
			tql_pkg::ST_IDLE, tql_pkg::ST_RESP: begin
				state_d = accept ? tql_pkg::ST_DECIDE : tql_pkg::ST_IDLE;
			end
			tql_pkg::ST_DECIDE: begin
				if (status.err || (status.mode == tql_pkg::MODE_SELECT && status.explore))
					state_d = tql_pkg::ST_RESP;
				else
					state_d = tql_pkg::ST_SCAN;
			end
			tql_pkg::ST_SCAN: begin
				if (status.scan_last) state_d = tql_pkg::ST_SCAN_END;
			end
			tql_pkg::ST_SCAN_END: begin
				state_d = (status.mode == tql_pkg::MODE_UPDATE) ? tql_pkg::ST_Q_READ
				                                                 : tql_pkg::ST_RESP;
			end
			tql_pkg::ST_Q_READ: state_d = tql_pkg::ST_Q_WAIT;
			tql_pkg::ST_Q_WAIT: state_d = tql_pkg::ST_MUL;
			tql_pkg::ST_MUL:    state_d = tql_pkg::ST_WRITE;
			tql_pkg::ST_WRITE:  state_d = tql_pkg::ST_RESP;
			default:            state_d = tql_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		unique case (state_q)
			tql_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
			tql_pkg::ST_DECIDE: cmd.decide     = 1'b1;
			tql_pkg::ST_SCAN:   cmd.scan_issue = 1'b1;
			tql_pkg::ST_Q_READ: cmd.q_read     = 1'b1;
			tql_pkg::ST_Q_WAIT: cmd.q_capture  = 1'b1;
			tql_pkg::ST_MUL:    cmd.mul        = 1'b1;
			tql_pkg::ST_WRITE:  cmd.write      = 1'b1;
			tql_pkg::ST_RESP:   cmd.finish     = 1'b1;
			default: ;
		endcase
	end

	a_scan_end_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tql_pkg::ST_SCAN_END |->
			$past(state_q == tql_pkg::ST_SCAN) && $past(status.scan_last))
		else $error("scan ended before the last entry was issued");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tql_pkg::ST_CLEAR |=> !$past(cmd.accept))
		else $error("transaction accepted during table clear");

endmodule

`default_nettype wire

// File: rtl/tql_dp.sv
// ----------------------------------------------------------------------------
// tql_dp
// Datapath of the Q-learning engine: configuration registers, exploration
// rate, value table, row maximum scan and fixed-point update arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module tql_dp #(
	parameter int STATE_COUNT  = 32768,
	parameter int ACTION_COUNT = 5
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tql_pkg::cmd_t                  cmd,
	output      tql_pkg::status_t               status,
	input  wire tql_pkg::item_t                 item,
	input  wire logic                           cfg_we,
	input  wire logic [tql_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tql_pkg::CFG_DATA_W-1:0] cfg_data,
	output      logic                           done,
	output      tql_pkg::result_t               result
);

	localparam int DEPTH = STATE_COUNT * ACTION_COUNT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(ACTION_COUNT);
	localparam logic [31:0] STATES  = 32'(STATE_COUNT);
	localparam logic [31:0] ACTIONS = 32'(ACTION_COUNT);
	localparam logic signed [36:0] Q_MAX = 37'(32'sh7FFF_FFFF);
	localparam logic signed [36:0] Q_MIN = 37'(32'sh8000_0000);

	// configuration and rate
	logic [15:0] alpha_q, gamma_q, floor_q, decay_q, rate_q;

	// item and decision
	tql_pkg::item_t item_q;
	logic           err_q, explore_q;
	logic [AW-1:0]  base_q, qaddr_q;
	logic           s_bad, ns_bad, at_bad, ea_bad, err_c, explore_c;
	logic [14:0]    row_sel;

	// scan
	logic [CW-1:0]      cnt_q, idx_s1, best_q;
	logic               issue_s1;
	logic signed [31:0] max_q;

	// clear sweep
	logic [AW-1:0] clr_q;

	// memory port
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, rd_data;
	logic signed [31:0] rd_val;

	// arithmetic
	logic signed [48:0] gprod_q, g_sum;
	logic signed [32:0] g_rnd;
	logic signed [31:0] q_q, newq_q, q_sat;
	logic signed [34:0] diff_q;
	logic signed [51:0] aprod_q, a_sum;
	logic signed [35:0] a_rnd;
	logic signed [36:0] nq_full;
	logic [31:0]        dprod_q, d_sum;
	logic [15:0]        d_rnd, rate_next;

	logic             done_q;
	tql_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= tql_pkg::RST_LEARNING_RATE;
			gamma_q <= tql_pkg::RST_DISCOUNT_FACTOR;
			floor_q <= tql_pkg::RST_EXPLORATION_FLOOR;
			decay_q <= tql_pkg::RST_EXPLORATION_DECAY;
			rate_q  <= tql_pkg::RST_EXPLORATION_START;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tql_pkg::REG_LEARNING_RATE:     alpha_q <= cfg_data;
					tql_pkg::REG_DISCOUNT_FACTOR:   gamma_q <= cfg_data;
					tql_pkg::REG_EXPLORATION_FLOOR: floor_q <= cfg_data;
					tql_pkg::REG_EXPLORATION_DECAY: decay_q <= cfg_data;
					default: ;
				endcase
			end
			priority if (cmd.write) begin
				rate_q <= rate_next;
			end else if (cfg_we && cfg_index == tql_pkg::REG_EXPLORATION_START) begin
				rate_q <= cfg_data;
			end else begin
				rate_q <= rate_q;
			end
		end
	end

	// index checks and row addresses
	always_comb begin
		s_bad     = 32'(item_q.state_index) >= STATES;
		ns_bad    = 32'(item_q.next_state_index) >= STATES;
		at_bad    = 32'(item_q.action_taken) >= ACTIONS;
		ea_bad    = 32'(item_q.explore_action) >= ACTIONS;
		err_c     = (item_q.mode == tql_pkg::MODE_UPDATE) ? (s_bad || ns_bad || at_bad)
		                                                  : (s_bad || ea_bad);
		explore_c = item_q.explore_draw < rate_q;
		row_sel   = (item_q.mode == tql_pkg::MODE_UPDATE) ? item_q.next_state_index
		                                                  : item_q.state_index;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
		if (cmd.decide) begin
			err_q     <= err_c;
			explore_q <= explore_c;
			base_q    <= AW'(32'(row_sel) * ACTIONS);
			qaddr_q   <= AW'(32'(item_q.state_index) * ACTIONS + 32'(item_q.action_taken));
		end
	end

	// row scan: one read issued per cycle, compared as it returns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			clr_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			issue_s1 <= cmd.scan_issue;
			done_q   <= cmd.finish;
			if (cmd.clear_step) clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			cnt_q <= '0;
		end else if (cmd.scan_issue) begin
			cnt_q <= cnt_q + CW'(1);
		end
		idx_s1 <= cnt_q;
		// strict greater keeps the lowest index on ties
		if (issue_s1 && (idx_s1 == '0 || rd_val > max_q)) begin
			max_q  <= rd_val;
			best_q <= idx_s1;
		end
	end

	assign ram_we    = cmd.clear_step || cmd.write;
	assign ram_waddr = cmd.clear_step ? clr_q : qaddr_q;
	assign ram_wdata = cmd.clear_step ? '0 : q_sat;
	assign ram_re    = cmd.scan_issue || cmd.q_read;
	assign ram_raddr = cmd.q_read ? qaddr_q : base_q + AW'(cnt_q);
	assign rd_val    = $signed(rd_data);

	tql_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// update arithmetic: products rounded, new value saturated, rate held at the floor
	always_comb begin
		g_sum     = gprod_q + 49'(tql_pkg::ROUND_BIAS);
		g_rnd     = $signed(g_sum[48:16]);
		a_sum     = aprod_q + 52'(tql_pkg::ROUND_BIAS);
		a_rnd     = $signed(a_sum[51:16]);
		nq_full   = 37'(q_q) + 37'(a_rnd);
		if (nq_full > Q_MAX)
			q_sat = 32'(Q_MAX);
		else if (nq_full < Q_MIN)
			q_sat = 32'(Q_MIN);
		else
			q_sat = 32'(nq_full);
		d_sum     = dprod_q + 32'(tql_pkg::ROUND_BIAS);
		d_rnd     = d_sum[31:16];
		rate_next = (d_rnd < floor_q) ? floor_q : d_rnd;
	end

	always_ff @(posedge clk) begin
		if (cmd.q_read) begin
			gprod_q <= $signed({1'b0, gamma_q}) * max_q;
			dprod_q <= 32'(rate_q) * 32'(decay_q);
		end
		if (cmd.q_capture) begin
			q_q    <= rd_val;
			diff_q <= 35'(item_q.reward) + 35'(g_rnd) - 35'(rd_val);
		end
		if (cmd.mul) begin
			aprod_q <= $signed({1'b0, alpha_q}) * diff_q;
		end
		if (cmd.write) begin
			newq_q <= q_sat;
		end
		if (cmd.finish) begin
			result_q.index_error     <= err_q;
			result_q.exploration_now <= rate_q;
			if (err_q) begin
				result_q.chosen_action <= '0;
				result_q.explored      <= 1'b0;
				result_q.new_q_value   <= '0;
			end else if (item_q.mode == tql_pkg::MODE_UPDATE) begin
				result_q.chosen_action <= '0;
				result_q.explored      <= 1'b0;
				result_q.new_q_value   <= newq_q;
			end else begin
				result_q.chosen_action <= explore_q ? item_q.explore_action : 3'(best_q);
				result_q.explored      <= explore_q;
				result_q.new_q_value   <= '0;
			end
		end
	end

	always_comb begin
		status.clear_last = clr_q == AW'(DEPTH - 1);
		status.scan_last  = cnt_q == CW'(ACTION_COUNT - 1);
		status.err        = err_c;
		status.explore    = explore_c;
		status.mode       = item_q.mode;
	end

	assign done   = done_q;
	assign result = result_q;

	a_no_write_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> !err_q)
		else $error("table written for a transaction with an index error");

	a_rate_above_floor: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.write) |-> rate_q >= $past(floor_q))
		else $error("exploration rate below floor after decay");

endmodule

`default_nettype wire
